FILE: rtl/core/ppau_pkg.sv
package ppau_pkg;

  localparam int unsigned MODE_W     = 3;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned PITCH_W    = 14;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned ROW_W      = POS_W + PITCH_W;
  localparam int unsigned XOFF_W     = POS_W + 2;
  localparam int unsigned ADDR_W     = ROW_W + 1;
  localparam int unsigned NB_W       = 3;

  localparam logic [MODE_W-1:0] BPP_32 = 3'd0;
  localparam logic [MODE_W-1:0] BPP_24 = 3'd1;
  localparam logic [MODE_W-1:0] BPP_16 = 3'd2;
  localparam logic [MODE_W-1:0] BPP_8  = 3'd3;
  localparam logic [MODE_W-1:0] BPP_1  = 3'd4;

  localparam logic CFG_BPP_MODE   = 1'b0;
  localparam logic CFG_LINE_PITCH = 1'b1;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic                start;
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [PITCH_W-1:0]  pitch;
  } agen_req_t;

  typedef struct packed {
    logic              done;
    logic              oor;
    logic [ADDR_W-1:0] addr;
  } agen_res_t;

  // Bytes touched per pixel; zero marks a mode that is not supported.
  function automatic logic [NB_W-1:0] nbytes(input logic [MODE_W-1:0] mode);
    logic [NB_W-1:0] n;
    unique case (mode)
      BPP_32:  n = 3'd4;
      BPP_24:  n = 3'd3;
      BPP_16:  n = 3'd2;
      BPP_8:   n = 3'd1;
      BPP_1:   n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/ppau_if.sv
interface ppau_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [ppau_pkg::POS_W-1:0] pos_x;
  logic [ppau_pkg::POS_W-1:0] pos_y;
  logic [ppau_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, func, pos_x, pos_y, pixel_value, input ready);
  modport sink (input valid, func, pos_x, pos_y, pixel_value, output ready);
endinterface

interface ppau_out_if;
  logic                       valid;
  logic                       ready;
  logic [ppau_pkg::PIX_W-1:0] read_value;
  logic                       out_of_range;

  modport source (output valid, read_value, out_of_range, input ready);
  modport sink (input valid, read_value, out_of_range, output ready);
endinterface

FILE: rtl/core/packed_pixel_access_unit.sv
// From accept to a valid result: address generation in ppau_agen, then a read
// and a capture step per byte read or a write step per byte written (a 1 bpp
// write is a read and a capture step that writes the byte back), then a load
// into the output register once it is free. An unsupported mode goes straight
// to that load, and the next item is accepted only after the load is made.
// Reset clears the mode and pitch registers and the control; store is not cleared.
module packed_pixel_access_unit #(
  parameter int unsigned STORE_BYTES = 262144
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ppau_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ppau_in_if.sink                       in_ch,
  ppau_out_if.source                    out_ch
);

  localparam int unsigned AW = $clog2(STORE_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AGEN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0]                       state_d, state_q;
  logic [ppau_pkg::MODE_W-1:0]      bpp_q;
  logic [ppau_pkg::PITCH_W-1:0]     pitch_q;
  logic                             func_d, func_q;
  logic [ppau_pkg::PIX_W-1:0]       colour_d, colour_q;
  logic [ppau_pkg::MODE_W-1:0]      mode_d, mode_q;
  logic [2:0]                       bitpos_d, bitpos_q;
  logic [ppau_pkg::NB_W-1:0]        nb_d, nb_q;
  logic [1:0]                       k_d, k_q;
  logic [AW-1:0]                    addr_d, addr_q;
  logic [ppau_pkg::PIX_W-1:0]       rd_d, rd_q;
  logic [ppau_pkg::PIX_W-1:0]       res_rv_d, res_rv_q;
  logic                             res_oor_d, res_oor_q;
  logic                             out_valid_q;
  logic [ppau_pkg::PIX_W-1:0]       out_rv_q;
  logic                             out_oor_q;
  logic                             out_load;
  logic                             in_acc;
  logic                             last;
  logic                             ram_we;
  logic [AW-1:0]                    ram_addr;
  logic [7:0]                       ram_wdata, ram_rdata;
  ppau_pkg::agen_req_t              agen_req;
  ppau_pkg::agen_res_t              agen_res;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = state_q == S_IDLE;
  assign last        = ({1'b0, k_q} + 3'd1) == nb_q;

  assign agen_req.start = in_acc && (ppau_pkg::nbytes(bpp_q) != '0);
  assign agen_req.mode  = bpp_q;
  assign agen_req.pos_x = in_ch.pos_x;
  assign agen_req.pos_y = in_ch.pos_y;
  assign agen_req.pitch = pitch_q;

  ppau_agen #(
    .STORE_BYTES(STORE_BYTES)
  ) u_agen (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (agen_req),
    .res_o (agen_res)
  );

  ppau_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    logic [7:0] merged;
    merged    = ram_rdata;
    merged[bitpos_q] = colour_q[0];
    state_d   = state_q;
    func_d    = func_q;
    colour_d  = colour_q;
    mode_d    = mode_q;
    bitpos_d  = bitpos_q;
    nb_d      = nb_q;
    k_d       = k_q;
    addr_d    = addr_q;
    rd_d      = rd_q;
    res_rv_d  = res_rv_q;
    res_oor_d = res_oor_q;
    ram_we    = 1'b0;
    ram_addr  = addr_q + AW'(k_q);
    ram_wdata = colour_q[{k_q, 3'b000} +: 8];
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d   = in_ch.func;
          colour_d = in_ch.pixel_value;
          mode_d   = bpp_q;
          bitpos_d = 3'd7 - in_ch.pos_x[2:0];
          nb_d     = ppau_pkg::nbytes(bpp_q);
          k_d      = '0;
          rd_d     = '0;
          if (ppau_pkg::nbytes(bpp_q) == '0) begin
            res_rv_d  = '0;
            res_oor_d = 1'b0;
            state_d   = S_HOLD;
          end else begin
            state_d = S_AGEN;
          end
        end
      end
      S_AGEN: begin
        if (agen_res.done) begin
          addr_d = agen_res.addr[AW-1:0];
          if (agen_res.oor) begin
            res_rv_d  = '0;
            res_oor_d = 1'b1;
            state_d   = S_HOLD;
          end else if (func_q == ppau_pkg::FUNC_WRITE && mode_q != ppau_pkg::BPP_1) begin
            state_d = S_WR;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        res_oor_d = 1'b0;
        if (mode_q == ppau_pkg::BPP_1) begin
          // Single-bit pixels: the byte just read is either returned as one
          // bit or written back with that bit replaced.
          if (func_q == ppau_pkg::FUNC_WRITE) begin
            ram_we    = 1'b1;
            ram_wdata = merged;
            res_rv_d  = '0;
          end else begin
            res_rv_d = ppau_pkg::PIX_W'(ram_rdata[bitpos_q]);
          end
          state_d = S_HOLD;
        end else begin
          rd_d[{k_q, 3'b000} +: 8] = ram_rdata;
          if (last) begin
            res_rv_d = rd_d;
            state_d  = S_HOLD;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_RD;
          end
        end
      end
      S_WR: begin
        ram_we = 1'b1;
        if (last) begin
          res_rv_d  = '0;
          res_oor_d = 1'b0;
          state_d   = S_HOLD;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_ch.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bpp_q       <= ppau_pkg::BPP_32;
      pitch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ppau_pkg::CFG_BPP_MODE:   bpp_q   <= cfg_data_i[ppau_pkg::MODE_W-1:0];
          ppau_pkg::CFG_LINE_PITCH: pitch_q <= cfg_data_i;
          default:                  pitch_q <= pitch_q;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    colour_q  <= colour_d;
    mode_q    <= mode_d;
    bitpos_q  <= bitpos_d;
    nb_q      <= nb_d;
    k_q       <= k_d;
    addr_q    <= addr_d;
    rd_q      <= rd_d;
    res_rv_q  <= res_rv_d;
    res_oor_q <= res_oor_d;
    if (out_load) begin
      out_rv_q  <= res_rv_q;
      out_oor_q <= res_oor_q;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.read_value   = out_rv_q;
  assign out_ch.out_of_range = out_oor_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_WR || state_q == S_CAP))
    else $error("frame store written outside a write step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    agen_res.done |-> state_q == S_AGEN)
    else $error("address result arrived with no item waiting for it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_WR) |-> ({1'b0, k_q} < nb_q))
    else $error("byte lane beyond the pixel width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_oor_q) |-> out_rv_q == '0)
    else $error("out-of-range item returned a nonzero pixel");
`endif

endmodule

FILE: rtl/core/ppau_ram.sv
module ppau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/core/ppau_agen.sv
module ppau_agen #(
  parameter int unsigned STORE_BYTES = 262144
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppau_pkg::agen_req_t req_i,
  output ppau_pkg::agen_res_t res_o
);

  localparam logic [ppau_pkg::ADDR_W:0] StoreLim = (ppau_pkg::ADDR_W + 1)'(STORE_BYTES);

  logic                          v1_q, v2_q;
  logic [ppau_pkg::ROW_W-1:0]    row_d, row_q;
  logic [ppau_pkg::XOFF_W-1:0]   xoff_d, xoff_q;
  logic [ppau_pkg::NB_W-1:0]     nb_q;
  logic [ppau_pkg::ADDR_W-1:0]   sum_d, addr_q;
  logic [ppau_pkg::ADDR_W:0]     end_d;
  logic                          oor_d, oor_q;

  assign row_d = ppau_pkg::ROW_W'(req_i.pos_y) * ppau_pkg::ROW_W'(req_i.pitch);

  always_comb begin
    unique case (req_i.mode)
      ppau_pkg::BPP_32: xoff_d = {req_i.pos_x, 2'b00};
      ppau_pkg::BPP_24: xoff_d = ppau_pkg::XOFF_W'({req_i.pos_x, 1'b0})
                                 + ppau_pkg::XOFF_W'(req_i.pos_x);
      ppau_pkg::BPP_16: xoff_d = ppau_pkg::XOFF_W'({req_i.pos_x, 1'b0});
      ppau_pkg::BPP_8:  xoff_d = ppau_pkg::XOFF_W'(req_i.pos_x);
      ppau_pkg::BPP_1:  xoff_d = ppau_pkg::XOFF_W'(req_i.pos_x[ppau_pkg::POS_W-1:3]);
      default:          xoff_d = '0;
    endcase
  end

  // Second stage: row base plus column offset, then the end of the pixel
  // is checked against the store size.
  assign sum_d = ppau_pkg::ADDR_W'(row_q) + ppau_pkg::ADDR_W'(xoff_q);
  assign end_d = {1'b0, sum_d} + (ppau_pkg::ADDR_W + 1)'(nb_q);
  assign oor_d = end_d > StoreLim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    xoff_q <= xoff_d;
    nb_q   <= ppau_pkg::nbytes(req_i.mode);
    addr_q <= sum_d;
    oor_q  <= oor_d;
  end

  assign res_o.done = v2_q;
  assign res_o.oor  = oor_q;
  assign res_o.addr = addr_q;

endmodule
